>>> hdl/csef_pkg.sv
package csef_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // line store address and counter widths follow the frame limits
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = ADDR_W;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  // register widths fixed by the register map
  localparam int WREG_W = 11;
  localparam int HREG_W = 13;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // register index codes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // 3x3 window, index 0 top left, 8 bottom right
  typedef pix_t [8:0] win_t;

  typedef logic [8:0][7:0] chan_win_t;

  // one line store entry: pixel two rows up and pixel one row up
  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_pair_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    line_pair_t        data;
  } wr_req_t;

  function automatic logic signed [12:0] px(input logic [7:0] v);
    return $signed({5'd0, v});
  endfunction

  // |s| saturated to 255, same as clamp(s) + clamp(-s)
  function automatic logic [7:0] sat_abs(input logic signed [12:0] s);
    logic [12:0] a;
    a = (s < 0) ? 13'(-s) : 13'(s);
    return (a > 13'd255) ? 8'd255 : a[7:0];
  endfunction

  function automatic logic [7:0] edge_mag(input chan_win_t p);
    logic signed [12:0] s0, s1, s2, s3;
    logic [9:0] total;
    s0 = px(p[2]) - px(p[0]) + 13'(2 * px(p[5])) - 13'(2 * px(p[3])) + px(p[8]) - px(p[6]);
    s1 = px(p[1]) + 13'(2 * px(p[2])) - px(p[3]) + px(p[5]) - 13'(2 * px(p[6])) - px(p[7]);
    s2 = px(p[0]) + 13'(2 * px(p[1])) + px(p[2]) - px(p[6]) - 13'(2 * px(p[7])) - px(p[8]);
    s3 = 13'(2 * px(p[0])) + px(p[1]) + px(p[3]) - px(p[5]) - px(p[7]) - 13'(2 * px(p[8]));
    total = 10'(sat_abs(s0)) + 10'(sat_abs(s1)) + 10'(sat_abs(s2)) + 10'(sat_abs(s3));
    return {1'b0, total[9:3]};
  endfunction

endpackage

>>> hdl/compass_sobel_edge_filter.sv
// Eight-direction compass edge filter on an RGB raster stream.
// in_*: one pixel per item in raster order, top row first; counting starts
// at reset and wraps after the last pixel of a frame (no frame sync).
// out_*: result items, each with its own row and column; tlast marks the
// last result caused by one input item. Results trail the input by one row
// and one column; a row-end pixel also gives the right border pixel of the
// row above, and last-row pixels give their own border pixels, so up to
// four results follow one item. Border pixels are zero.
// cfg_*: APB registers image_width (0x0) and image_height (0x4), to be
// written only while the block is idle; the block itself does not enforce this.
// An accepted item goes into the input register, then, when no stall holds
// it there, into the single output register. Throughput: one item per cycle
// while each item gives at most one result and out_tready stays high; an item
// with more results holds the input while the output register emits one result per cycle of high out_tready.
// Reset: counters go to zero and the 1024-entry line store is swept to zero,
// one entry a cycle; in_tready stays low until the sweep is done.
// Stall: when out_tready is low the result holds; at most one more item is taken
// into the input register, then in_tready drops.
module compass_sobel_edge_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in, green_in, blue_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // red_out, green_out, blue_out, out_row, out_col, zero pad
  output logic        out_tlast,  // run_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int COL_W  = csef_pkg::COL_W;
  localparam int ROW_W  = csef_pkg::ROW_W;
  localparam int WREG_W = csef_pkg::WREG_W;
  localparam int HREG_W = csef_pkg::HREG_W;

  // configuration
  logic [WREG_W-1:0] width_r;
  logic [HREG_W-1:0] height_r;
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WREG_W'(csef_pkg::WIDTH_RESET);
      height_r <= HREG_W'(csef_pkg::HEIGHT_RESET);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == csef_pkg::REG_WIDTH) begin
        width_r <= cfg_pwdata[WREG_W-1:0];
      end else begin
        height_r <= cfg_pwdata[HREG_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == csef_pkg::REG_HEIGHT) ? 32'(height_r) : 32'(width_r);

  always_comb begin
    if (width_r < WREG_W'(3)) begin
      w_eff = WREG_W'(3);
    end else if (width_r > WREG_W'(csef_pkg::MAX_WIDTH)) begin
      w_eff = WREG_W'(csef_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r < HREG_W'(3)) begin
      h_eff = HREG_W'(3);
    end else if (height_r > HREG_W'(csef_pkg::MAX_HEIGHT)) begin
      h_eff = HREG_W'(csef_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // position of the next input item
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic             last_col, last_row, inner;
  logic [3:0]       mask_nxt;

  assign last_col = WREG_W'(col_r) >= (w_eff - 1'b1);
  assign last_row = HREG_W'(row_r) >= (h_eff - 1'b1);
  assign inner    = (row_r >= ROW_W'(2)) && (HREG_W'(row_r) < h_eff) &&
                    (col_r >= COL_W'(2)) && (WREG_W'(col_r) < w_eff);

  // results in order: filtered, right border above, bottom left, bottom corner
  assign mask_nxt[0] = (row_r != '0) && (col_r != '0);
  assign mask_nxt[1] = (row_r != '0) && last_col;
  assign mask_nxt[2] = last_row && (col_r != '0);
  assign mask_nxt[3] = last_row && last_col;

  // input register
  logic             s1_valid_r;
  csef_pkg::pix_t   s1_pix_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic [3:0]       s1_mask_r;
  logic             s1_inner_r;

  // result register
  logic [3:0]       s2_mask_r;
  csef_pkg::pix_t   s2_grad_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;

  logic [3:0] low_bit, rest;
  logic       s2_free, adv, in_acc, out_acc, clear_done;

  csef_pkg::line_pair_t rd_data;
  csef_pkg::wr_req_t    wr;
  csef_pkg::win_t       win_r, win_nxt;
  csef_pkg::pix_t       grad;

  assign low_bit = s2_mask_r & (~s2_mask_r + 4'd1);
  assign rest    = s2_mask_r & ~low_bit;

  assign out_tvalid = s2_mask_r != '0;
  assign out_acc    = out_tvalid && out_tready;
  assign s2_free    = !out_tvalid || (out_tready && rest == '0);
  assign adv        = s1_valid_r && s2_free;
  assign in_tready  = clear_done && (!s1_valid_r || adv);
  assign in_acc     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r.red   <= in_tdata[7:0];
      s1_pix_r.green <= in_tdata[15:8];
      s1_pix_r.blue  <= in_tdata[23:16];
      s1_row_r       <= row_r;
      s1_col_r       <= col_r;
      s1_mask_r      <= mask_nxt;
      s1_inner_r     <= inner;
    end
  end

  csef_linebuf u_linebuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_acc),
    .rd_addr    (col_r),
    .rd_data    (rd_data),
    .wr         (wr),
    .clear_done (clear_done)
  );

  always_comb begin
    wr.en          = adv;
    wr.addr        = s1_col_r;
    wr.data.older  = rd_data.newer;
    wr.data.newer  = s1_pix_r;
  end

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = rd_data.older;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = rd_data.newer;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_r <= win_nxt;
    end
  end

  csef_filter u_filter (
    .win  (win_nxt),
    .grad (grad)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_mask_r <= '0;
    end else if (adv) begin
      s2_mask_r <= s1_mask_r;
    end else if (out_acc) begin
      s2_mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_grad_r <= s1_inner_r ? grad : '0;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
    end
  end

  // pick the lowest pending result
  logic [ROW_W-1:0] o_row;
  logic [COL_W-1:0] o_col;
  csef_pkg::pix_t   o_pix;

  always_comb begin
    o_pix = '0;
    o_row = s2_row_r;
    o_col = s2_col_r;
    if (s2_mask_r[0]) begin
      o_pix = s2_grad_r;
      o_row = s2_row_r - 1'b1;
      o_col = s2_col_r - 1'b1;
    end else if (s2_mask_r[1]) begin
      o_row = s2_row_r - 1'b1;
    end else if (s2_mask_r[2]) begin
      o_col = s2_col_r - 1'b1;
    end
  end

  assign out_tdata = {2'b00, o_col, o_row, o_pix.blue, o_pix.green, o_pix.red};
  assign out_tlast = rest == '0;

endmodule

>>> hdl/csef_linebuf.sv
module csef_linebuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [csef_pkg::ADDR_W-1:0]   rd_addr,
  output csef_pkg::line_pair_t          rd_data,
  input  csef_pkg::wr_req_t             wr,
  output logic                          clear_done
);

  csef_pkg::line_pair_t mem [csef_pkg::MAX_WIDTH];
  csef_pkg::line_pair_t rd_data_r;

  logic [csef_pkg::ADDR_W-1:0] clr_cnt_r;
  logic                        clr_busy_r;

  // zero sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == csef_pkg::ADDR_W'(csef_pkg::MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign clear_done = !clr_busy_r;

endmodule

>>> hdl/csef_filter.sv
module csef_filter (
  input  csef_pkg::win_t win,
  output csef_pkg::pix_t grad
);

  csef_pkg::chan_win_t red_w, green_w, blue_w;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      red_w[i]   = win[i].red;
      green_w[i] = win[i].green;
      blue_w[i]  = win[i].blue;
    end
  end

  assign grad.red   = csef_pkg::edge_mag(red_w);
  assign grad.green = csef_pkg::edge_mag(green_w);
  assign grad.blue  = csef_pkg::edge_mag(blue_w);

endmodule

>>> hdl/csef_checker.sv
module csef_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // more results of the same item follow directly
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("result run broken before tlast");

  // first row and first column are border pixels
  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[35:24] == 12'd0 || out_tdata[45:36] == 10'd0)
      |-> out_tdata[23:0] == 24'd0)
    else $error("border result not zero");

  // sum of four saturated bytes divided by eight stays below 128
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7] && !out_tdata[15] && !out_tdata[23])
    else $error("edge value out of range");

  // line store sweep starts at reset
  a_reset_busy: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_tready && !out_tvalid)
    else $error("block ready right after reset");

endmodule

bind compass_sobel_edge_filter csef_checker u_csef_checker (.*);

>>> dv/compass_sobel_edge_filter_test.sv
`timescale 1ns / 100ps

module compass_sobel_edge_filter_test;

  typedef csef_pkg::pix_t pix_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } edge_result_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_EXTREME,
    FILL_SMOOTH
  } fill_mode_t;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red, green, blue
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // red, green, blue, row, col, zero pad
  logic        out_tlast;  // last result of one pixel
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state
  pix_t         older_row [csef_pkg::MAX_WIDTH];
  pix_t         newer_row [csef_pkg::MAX_WIDTH];
  pix_t         window [9];
  int           row_pos;
  int           col_pos;
  logic [10:0]  width_reg;
  logic [12:0]  height_reg;
  edge_result_t pending_edges [$];

  int mismatches;
  int pixels_sent;
  int hold_request;
  int cycles = 0;
  bit quiet;

  compass_sobel_edge_filter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sum of the four saturated |response| values is the same as the eight
  // clamped compass kernels
  function automatic logic [7:0] channel_edge(input int p [9]);
    int s [4];
    int total;
    int mag;
    s[0] = p[2] - p[0] + 2 * p[5] - 2 * p[3] + p[8] - p[6];
    s[1] = p[1] + 2 * p[2] - p[3] + p[5] - 2 * p[6] - p[7];
    s[2] = p[0] + 2 * p[1] + p[2] - p[6] - 2 * p[7] - p[8];
    s[3] = 2 * p[0] + p[1] + p[3] - p[5] - p[7] - 2 * p[8];
    total = 0;
    foreach (s[k]) begin
      mag = (s[k] < 0) ? -s[k] : s[k];
      total += (mag > 255) ? 255 : mag;
    end
    return 8'(total / 8);
  endfunction

  function automatic edge_result_t make_result(input int row, input int col,
                                               input bit interior);
    edge_result_t res;
    int pr [9];
    int pg [9];
    int pb [9];
    int i;
    for (i = 0; i < 9; i++) begin
      pr[i] = window[i].red;
      pg[i] = window[i].green;
      pb[i] = window[i].blue;
    end
    res.red   = interior ? channel_edge(pr) : 8'd0;
    res.green = interior ? channel_edge(pg) : 8'd0;
    res.blue  = interior ? channel_edge(pb) : 8'd0;
    res.row   = 12'(row);
    res.col   = 10'(col);
    res.last  = 1'b0;
    return res;
  endfunction

  task automatic predict_edges(input pix_t p);
    edge_result_t res [4];
    pix_t upper;
    pix_t middle;
    int   w, h, r, c, cnt, k;
    bit   lastc, lastr, interior;
    w = width_reg;
    h = height_reg;
    if (w < 3) w = 3;
    if (w > csef_pkg::MAX_WIDTH) w = csef_pkg::MAX_WIDTH;
    if (h < 3) h = 3;
    if (h > csef_pkg::MAX_HEIGHT) h = csef_pkg::MAX_HEIGHT;
    r = row_pos;
    c = col_pos;
    upper  = older_row[c];
    middle = newer_row[c];
    for (k = 0; k < 3; k++) begin
      window[3 * k]     = window[3 * k + 1];
      window[3 * k + 1] = window[3 * k + 2];
    end
    window[2] = upper;
    window[5] = middle;
    window[8] = p;
    older_row[c] = middle;
    newer_row[c] = p;
    lastc = (c >= w - 1);
    lastr = (r >= h - 1);
    cnt = 0;
    if (r >= 1 && c >= 1) begin
      interior = (r - 1 >= 1) && (r - 1 < h - 1) && (c - 1 >= 1) && (c - 1 < w - 1);
      res[cnt++] = make_result(r - 1, c - 1, interior);
    end
    // border pixels completed by this one
    if (r >= 1 && lastc) res[cnt++] = make_result(r - 1, c, 1'b0);
    if (lastr && c >= 1) res[cnt++] = make_result(r, c - 1, 1'b0);
    if (lastr && lastc) res[cnt++] = make_result(r, c, 1'b0);
    if (cnt > 0) res[cnt - 1].last = 1'b1;
    for (k = 0; k < cnt; k++) pending_edges.push_back(res[k]);
    if (lastc) begin
      col_pos = 0;
      row_pos = lastr ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin : monitor
    edge_result_t got;
    edge_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.red   = out_tdata[7:0];
      got.green = out_tdata[15:8];
      got.blue  = out_tdata[23:16];
      got.row   = out_tdata[35:24];
      got.col   = out_tdata[45:36];
      got.last  = out_tlast;
      if (pending_edges.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, got r=%0d g=%0d b=%0d row=%0d col=%0d last=%0b",
                 $time, got.red, got.green, got.blue, got.row, got.col, got.last);
      end else begin
        want = pending_edges.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected r=%0d g=%0d b=%0d row=%0d col=%0d last=%0b",
                   $time, want.red, want.green, want.blue, want.row, want.col, want.last);
          $display("%0t:   actual r=%0d g=%0d b=%0d row=%0d col=%0d last=%0b",
                   $time, got.red, got.green, got.blue, got.row, got.col, got.last);
        end
      end
    end
    if (rst_n && in_tvalid && in_tready)
      predict_edges('{red: in_tdata[7:0], green: in_tdata[15:8], blue: in_tdata[23:16]});
  end

  // result side: random stalls, plus one long hold on request
  initial begin : result_sink
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall = $urandom_range(0, 6);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic pix_t random_pixel(input fill_mode_t mode);
    pix_t p;
    case (mode)
      FILL_EXTREME: begin
        p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      FILL_SMOOTH: begin
        p.red   = 8'($urandom_range(100, 140));
        p.green = 8'($urandom_range(100, 140));
        p.blue  = 8'($urandom_range(100, 140));
      end
      default: p = pix_t'($urandom);
    endcase
    return p;
  endfunction

  task automatic send_pixel(input pix_t p);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {p.blue, p.green, p.red};
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // pixels of the first row give no result, so wait on for a settle time after the expected results are all seen
  task automatic wait_idle;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == csef_pkg::REG_WIDTH) width_reg = value[10:0];
    else height_reg = value[12:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // small frames with hard edges in every direction: a 3x3 frame, then a 4x3 frame after the block goes idle
  task automatic test_small_frames;
    pix_t p;
    int   i, r, c;
    write_reg(csef_pkg::REG_WIDTH, 32'd3);
    write_reg(csef_pkg::REG_HEIGHT, 32'd3);
    for (i = 0; i < 9; i++) begin
      p.red   = (i % 2 == 0) ? 8'h00 : 8'hFF;
      p.green = 8'hFF;
      p.blue  = 8'(i * 31);
      send_pixel(p);
    end
    wait_idle;
    write_reg(csef_pkg::REG_WIDTH, 32'd4);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 4; c++) begin
        p.red   = (c >= 2) ? 8'hFF : 8'h00;
        p.green = (r >= 1) ? 8'hFF : 8'h00;
        p.blue  = (c > r) ? 8'hFF : 8'h00;
        send_pixel(p);
      end
    end
  endtask

  // register extremes, out-of-range values and size changes mid-frame
  task automatic test_size_limits;
    int i;
    wait_idle;
    write_reg(csef_pkg::REG_WIDTH, 32'd1024);
    write_reg(csef_pkg::REG_HEIGHT, 32'd4096);
    for (i = 0; i < 6; i++) send_pixel(random_pixel(FILL_RANDOM));
    wait_idle;
    write_reg(csef_pkg::REG_WIDTH, 32'd2047);
    write_reg(csef_pkg::REG_HEIGHT, 32'd8191);
    for (i = 0; i < 4; i++) send_pixel(random_pixel(FILL_EXTREME));
    wait_idle;
    // upper bits ignored: width 0, column already past the end
    write_reg(csef_pkg::REG_WIDTH, 32'hFFFF_F800);
    for (i = 0; i < 7; i++) send_pixel(random_pixel(FILL_RANDOM));
    wait_idle;
    // height 1, row past the end: this row is the last one
    write_reg(csef_pkg::REG_HEIGHT, 32'hFFFF_E001);
    for (i = 0; i < 6; i++) send_pixel(random_pixel(FILL_RANDOM));
  endtask

  // long output hold so the block backs up and drops in_tready
  task automatic test_output_stall;
    int i;
    wait_idle;
    write_reg(csef_pkg::REG_WIDTH, 32'd3);
    write_reg(csef_pkg::REG_HEIGHT, 32'd3);
    hold_request = 150;
    for (i = 0; i < 27; i++) send_pixel(random_pixel(FILL_RANDOM));
  endtask

  task automatic test_random_frames(input int target);
    fill_mode_t mode;
    int         w, h, n, i;
    while (pixels_sent < target) begin
      wait_idle;
      if (pixels_sent >= target - 60) quiet = 1'b1;
      case ($urandom_range(0, 7))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(11, 2047);
        default: w = $urandom_range(3, 10);
      endcase
      case ($urandom_range(0, 7))
        0:       h = $urandom_range(0, 2);
        1:       h = $urandom_range(7, 8191);
        default: h = $urandom_range(3, 6);
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(csef_pkg::REG_WIDTH, 32'(w));
      if ($urandom_range(0, 3) != 0) write_reg(csef_pkg::REG_HEIGHT, 32'(h));
      case ($urandom_range(0, 5))
        0:       mode = FILL_EXTREME;
        1:       mode = FILL_SMOOTH;
        default: mode = FILL_RANDOM;
      endcase
      n = $urandom_range(4, 40);
      for (i = 0; i < n; i++) send_pixel(random_pixel(mode));
    end
  endtask

  initial begin
    int i;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    quiet        = 1'b0;
    hold_request = 0;
    mismatches   = 0;
    pixels_sent  = 0;
    width_reg    = 11'(csef_pkg::WIDTH_RESET);
    height_reg   = 13'(csef_pkg::HEIGHT_RESET);
    row_pos      = 0;
    col_pos      = 0;
    for (i = 0; i < csef_pkg::MAX_WIDTH; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (i = 0; i < 9; i++) window[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // line store sweep runs first
    do @(posedge clk); while (!in_tready);

    test_small_frames;
    test_size_limits;
    test_output_stall;
    test_random_frames(360);

    wait_idle;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_edges.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
